### rtl/core/dbm_pkg.sv
package dbm_pkg;

	localparam int DEF_PATTERN_BYTES = 8;
	localparam int DEF_LINE_COLUMNS  = 1024;
	localparam int DEF_COUNT_BITS    = 16;

	localparam int CHAR_W     = 8;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 64;
	localparam int LENGTH_W   = 4;
	localparam int COUNT_W    = 16;
	localparam int LINE_W     = 16;
	localparam int COLUMN_W   = 10;
	localparam int OUT_DATA_W = 88;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_OPEN_PATTERN  = 2'd0,
		REG_OPEN_LENGTH   = 2'd1,
		REG_CLOSE_PATTERN = 2'd2,
		REG_CLOSE_LENGTH  = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_SEARCHING = 2'd0,
		ST_FOUND     = 2'd1,
		ST_FAILED    = 2'd2
	} status_t;

	localparam logic [7:0] RESET_OPEN_CHAR  = 8'd123;
	localparam logic [7:0] RESET_CLOSE_CHAR = 8'd125;

endpackage

### rtl/core/dbm_match.sv
module dbm_match #(
	parameter int PATTERN_BYTES = 8,
	parameter int LEN_BITS      = 4,
	parameter int COL_BITS      = 10
) (
	input  logic [PATTERN_BYTES*8-1:0] window,
	input  logic [PATTERN_BYTES*8-1:0] pattern,
	input  logic [LEN_BITS-1:0]        len,
	input  logic [COL_BITS-1:0]        column,
	output logic                       hit
);
	import dbm_pkg::*;

	localparam int LEN_CODES = 2 ** LEN_BITS;

	logic [LEN_CODES-1:0] hit_by_len;
	logic [LEN_BITS-1:0]  len_m1;

	// window byte 0 is the newest, it must equal the last pattern byte
	always_comb begin
		hit_by_len = '0;
		for (int l = 1; l <= PATTERN_BYTES; l++) begin
			hit_by_len[l] = 1'b1;
			for (int k = 0; k < l; k++) begin
				if (window[k*CHAR_W +: CHAR_W] != pattern[(l-1-k)*CHAR_W +: CHAR_W]) begin
					hit_by_len[l] = 1'b0;
				end
			end
		end
	end

	assign len_m1 = len - LEN_BITS'(1);
	assign hit = hit_by_len[len] && (column >= COL_BITS'(len_m1));

endmodule

### rtl/core/delimiter_block_matcher.sv
// a line end request passes the input register, then its result is put in the output register
// throughput: one request per cycle, set by the single registered pass of window compare
// and counter update, unless a line end waits on a held result; text bytes produce no result
// reset: asynchronous, clears search state and handshake state, delimiters return to
// a one-byte open brace and close brace
module delimiter_block_matcher #(
	parameter int PATTERN_BYTES = dbm_pkg::DEF_PATTERN_BYTES,
	parameter int LINE_COLUMNS  = dbm_pkg::DEF_LINE_COLUMNS,
	parameter int COUNT_BITS    = dbm_pkg::DEF_COUNT_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [dbm_pkg::CHAR_W-1:0]        s_axis_tdata, // char_code
	input  logic                              s_axis_tlast, // line_end
	input  logic                              s_axis_tuser, // restart
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// search_status, open_count, close_count, lines_seen, close_line, close_column,
	// open_column, open_in_first_line, zero pad
	output logic [dbm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dbm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [dbm_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import dbm_pkg::*;

	localparam int PW       = PATTERN_BYTES * CHAR_W;
	localparam int LEN_BITS = $clog2(PATTERN_BYTES + 1);
	localparam int COL_BITS = $clog2(LINE_COLUMNS);
	localparam logic [COL_BITS-1:0]   COL_MAX   = COL_BITS'(LINE_COLUMNS - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [LINE_W-1:0]     LINE_MAX  = '1;

	// configuration
	logic [PW-1:0]       open_pat_q, close_pat_q;
	logic [LEN_BITS-1:0] open_len_q, close_len_q;
	logic [LENGTH_W-1:0] cfg_len;
	logic [LEN_BITS-1:0] cfg_len_eff;

	assign cfg_ready = 1'b1;
	assign cfg_len   = cfg_data[LENGTH_W-1:0];

	always_comb begin
		if (cfg_len == '0) begin
			cfg_len_eff = LEN_BITS'(1);
		end else if (cfg_len > LENGTH_W'(PATTERN_BYTES)) begin
			cfg_len_eff = LEN_BITS'(PATTERN_BYTES);
		end else begin
			cfg_len_eff = LEN_BITS'(cfg_len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_pat_q  <= PW'(RESET_OPEN_CHAR);
			close_pat_q <= PW'(RESET_CLOSE_CHAR);
			open_len_q  <= LEN_BITS'(1);
			close_len_q <= LEN_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OPEN_PATTERN:  open_pat_q  <= cfg_data[PW-1:0];
				REG_OPEN_LENGTH:   open_len_q  <= cfg_len_eff;
				REG_CLOSE_PATTERN: close_pat_q <= cfg_data[PW-1:0];
				REG_CLOSE_LENGTH:  close_len_q <= cfg_len_eff;
				default: ;
			endcase
		end
	end

	// input register
	logic              valid_s1, last_s1, restart_s1, adv;
	logic [CHAR_W-1:0] char_s1;
	logic              out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	assign adv           = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1    <= s_axis_tdata;
			last_s1    <= s_axis_tlast;
			restart_s1 <= s_axis_tuser;
		end
	end

	// search state
	logic [PW-1:0]         win_q, cur_win, win_sh, nxt_win;
	logic [COL_BITS-1:0]   col_q, cur_col, nxt_col;
	logic [LEN_BITS-1:0]   ome_q, cur_ome, nxt_ome, cme_q, cur_cme, nxt_cme;
	logic [COUNT_BITS-1:0] open_tot_q, cur_open, nxt_open, close_tot_q, cur_close, nxt_close;
	logic [LINE_W-1:0]     line_tot_q, cur_line, nxt_line, lcl_q, cur_lcl, nxt_lcl;
	logic [COL_BITS-1:0]   lcc_q, cur_lcc, nxt_lcc, foc_q, cur_foc, nxt_foc;
	logic                  fos_q, cur_fos, nxt_fos, done_q, cur_done, nxt_done;
	logic                  open_hit, close_hit;
	status_t               status;

	assign cur_win   = restart_s1 ? '0 : win_q;
	assign cur_col   = restart_s1 ? '0 : col_q;
	assign cur_ome   = restart_s1 ? '0 : ome_q;
	assign cur_cme   = restart_s1 ? '0 : cme_q;
	assign cur_open  = restart_s1 ? '0 : open_tot_q;
	assign cur_close = restart_s1 ? '0 : close_tot_q;
	assign cur_line  = restart_s1 ? '0 : line_tot_q;
	assign cur_lcl   = restart_s1 ? '0 : lcl_q;
	assign cur_lcc   = restart_s1 ? '0 : lcc_q;
	assign cur_foc   = restart_s1 ? '0 : foc_q;
	assign cur_fos   = restart_s1 ? 1'b0 : fos_q;
	assign cur_done  = restart_s1 ? 1'b0 : done_q;

	generate
		if (PATTERN_BYTES == 1) begin : g_win_one
			assign win_sh = char_s1;
		end else begin : g_win_many
			assign win_sh = {cur_win[PW-CHAR_W-1:0], char_s1};
		end
	endgenerate

	dbm_match #(
		.PATTERN_BYTES(PATTERN_BYTES),
		.LEN_BITS     (LEN_BITS),
		.COL_BITS     (COL_BITS)
	) u_open_match (
		.window (win_sh),
		.pattern(open_pat_q),
		.len    (open_len_q),
		.column (cur_col),
		.hit    (open_hit)
	);

	dbm_match #(
		.PATTERN_BYTES(PATTERN_BYTES),
		.LEN_BITS     (LEN_BITS),
		.COL_BITS     (COL_BITS)
	) u_close_match (
		.window (win_sh),
		.pattern(close_pat_q),
		.len    (close_len_q),
		.column (cur_col),
		.hit    (close_hit)
	);

	always_comb begin
		nxt_win   = cur_win;
		nxt_col   = cur_col;
		nxt_ome   = cur_ome;
		nxt_cme   = cur_cme;
		nxt_open  = cur_open;
		nxt_close = cur_close;
		nxt_line  = cur_line;
		nxt_lcl   = cur_lcl;
		nxt_lcc   = cur_lcc;
		nxt_foc   = cur_foc;
		nxt_fos   = cur_fos;
		nxt_done  = cur_done;
		if (!cur_done) begin
			if (!last_s1) begin
				nxt_win = win_sh;
				if (cur_ome != '0) begin
					nxt_ome = cur_ome - LEN_BITS'(1);
				end else if (open_hit) begin
					nxt_open = (cur_open != COUNT_MAX) ? cur_open + COUNT_BITS'(1) : cur_open;
					nxt_ome  = open_len_q - LEN_BITS'(1);
					if (cur_line == '0 && !cur_fos) begin
						nxt_fos = 1'b1;
						nxt_foc = cur_col - COL_BITS'(nxt_ome);
					end
				end
				if (cur_cme != '0) begin
					nxt_cme = cur_cme - LEN_BITS'(1);
				end else if (close_hit) begin
					nxt_close = (cur_close != COUNT_MAX) ? cur_close + COUNT_BITS'(1) : cur_close;
					nxt_cme   = close_len_q - LEN_BITS'(1);
					nxt_lcl   = cur_line;
					nxt_lcc   = (cur_col != COL_MAX) ? cur_col + COL_BITS'(1) : cur_col;
				end
				nxt_col = (cur_col != COL_MAX) ? cur_col + COL_BITS'(1) : cur_col;
			end else begin
				nxt_line = (cur_line != LINE_MAX) ? cur_line + LINE_W'(1) : cur_line;
				nxt_win  = '0;
				nxt_col  = '0;
				nxt_ome  = '0;
				nxt_cme  = '0;
				nxt_done = (cur_open == cur_close);
			end
		end
	end

	always_comb begin
		if (!nxt_done) begin
			status = ST_SEARCHING;
		end else if (nxt_open != '0) begin
			status = ST_FOUND;
		end else begin
			status = ST_FAILED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= '0;
			col_q       <= '0;
			ome_q       <= '0;
			cme_q       <= '0;
			open_tot_q  <= '0;
			close_tot_q <= '0;
			line_tot_q  <= '0;
			lcl_q       <= '0;
			lcc_q       <= '0;
			foc_q       <= '0;
			fos_q       <= 1'b0;
			done_q      <= 1'b0;
		end else if (adv) begin
			win_q       <= nxt_win;
			col_q       <= nxt_col;
			ome_q       <= nxt_ome;
			cme_q       <= nxt_cme;
			open_tot_q  <= nxt_open;
			close_tot_q <= nxt_close;
			line_tot_q  <= nxt_line;
			lcl_q       <= nxt_lcl;
			lcc_q       <= nxt_lcc;
			foc_q       <= nxt_foc;
			fos_q       <= nxt_fos;
			done_q      <= nxt_done;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_data_q <= {1'b0, nxt_fos, COLUMN_W'(nxt_foc), COLUMN_W'(nxt_lcc), nxt_lcl,
				nxt_line, COUNT_W'(nxt_close), COUNT_W'(nxt_open), status};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
	a_done_balanced: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> open_tot_q == close_tot_q)
		else $error("finished search with unequal counts");

	a_line_end_clears_column: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> col_q == '0)
		else $error("column not cleared after line end");

	a_status_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q[1:0] != ST_SEARCHING |->
		out_data_q[COUNT_W+1:2] == out_data_q[2*COUNT_W+1:COUNT_W+2])
		else $error("final status with unequal counts");

	a_failed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q[1:0] == ST_FAILED |-> out_data_q[COUNT_W+1:2] == '0)
		else $error("failed status with open matches");
`endif

endmodule

### tb/sv/delimiter_block_matcher_tb.sv
`timescale 1ns / 100ps

module delimiter_block_matcher_tb;
	import dbm_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int COL_TOP = 1023;
	localparam int RANDOM_ITEMS = 1850;
	localparam int PHASE_ITEMS = 180;

	typedef struct {
		status_t     status;
		logic [15:0] opens;
		logic [15:0] closes;
		logic [15:0] lines;
		logic [15:0] close_line;
		logic [9:0]  close_col;
		logic [9:0]  open_col;
		logic        open_first;
	} line_report_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [CHAR_W-1:0]      s_axis_tdata = '0;   // char_code
	logic                   s_axis_tlast = 1'b0; // line_end
	logic                   s_axis_tuser = 1'b0; // restart
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// search_status, open_count, close_count, lines_seen, close_line, close_column,
	// open_column, open_in_first_line, zero pad
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	cfg_reg_t               cfg_index = REG_OPEN_PATTERN;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	delimiter_block_matcher dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// delimiter registers as written to the block, with the lengths kept unclamped
	logic [63:0] open_pat = 64'(RESET_OPEN_CHAR);
	logic [3:0]  open_len = 4'd1;
	logic [63:0] close_pat = 64'(RESET_CLOSE_CHAR);
	logic [3:0]  close_len = 4'd1;

	// search state
	logic [63:0] tail_bytes;
	int unsigned col_pos;
	int unsigned open_hold;
	int unsigned close_hold;
	logic [15:0] opens_seen;
	logic [15:0] closes_seen;
	logic [15:0] lines_done;
	logic [15:0] close_line_q;
	logic [9:0]  close_col_q;
	logic [9:0]  first_open_col;
	bit          first_open_hit;
	bit          search_over;

	line_report_t line_reports[$];
	int          error_count = 0;
	int unsigned items_sent = 0;
	int unsigned quiet_cycles = 0;
	bit          fast_mode = 1'b0;
	bit          restart_pending = 1'b0;
	int unsigned send_calm = 0;
	int unsigned rx_left = 0;
	bit          rx_on = 1'b0;
	logic [7:0]  phase_syms [4];

	function automatic int unsigned used_len(logic [3:0] l);
		if (l == 4'd0)
			return 1;
		if (l > 4'd8)
			return 8;
		return 32'(l);
	endfunction

	function automatic bit tail_matches(logic [63:0] win, logic [63:0] pat, int unsigned len,
			int unsigned pos);
		if (pos + 1 < len)
			return 1'b0;
		for (int unsigned j = 0; j < len; j++)
			if (win[8*(len-1-j) +: 8] != pat[8*j +: 8])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [15:0] bump(logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function void clear_search();
		tail_bytes = '0;
		col_pos = 0;
		open_hold = 0;
		close_hold = 0;
		opens_seen = '0;
		closes_seen = '0;
		lines_done = '0;
		close_line_q = '0;
		close_col_q = '0;
		first_open_col = '0;
		first_open_hit = 1'b0;
		search_over = 1'b0;
	endfunction

	function void scan_byte(logic [7:0] c);
		int unsigned olen;
		int unsigned clen;
		int unsigned pos;
		olen = used_len(open_len);
		clen = used_len(close_len);
		pos = col_pos;
		tail_bytes = {tail_bytes[55:0], c};
		if (open_hold > 0) begin
			open_hold--;
		end else if (tail_matches(tail_bytes, open_pat, olen, pos)) begin
			opens_seen = bump(opens_seen);
			open_hold = olen - 1;
			if (lines_done == 16'd0 && !first_open_hit) begin
				first_open_hit = 1'b1;
				first_open_col = 10'(pos + 1 - olen);
			end
		end
		if (close_hold > 0) begin
			close_hold--;
		end else if (tail_matches(tail_bytes, close_pat, clen, pos)) begin
			closes_seen = bump(closes_seen);
			close_hold = clen - 1;
			close_line_q = lines_done;
			close_col_q = 10'((pos < COL_TOP) ? pos + 1 : COL_TOP);
		end
		if (col_pos < COL_TOP)
			col_pos++;
	endfunction

	// returns 1 when the request closes a line and so yields a report
	function bit track_item(logic [7:0] c, bit le, bit rs, output line_report_t rep);
		rep = '{ST_SEARCHING, 16'd0, 16'd0, 16'd0, 16'd0, 10'd0, 10'd0, 1'b0};
		if (rs)
			clear_search();
		if (!le) begin
			if (!search_over)
				scan_byte(c);
			return 1'b0;
		end
		if (!search_over) begin
			lines_done = bump(lines_done);
			tail_bytes = '0;
			col_pos = 0;
			open_hold = 0;
			close_hold = 0;
			if (opens_seen == closes_seen)
				search_over = 1'b1;
		end
		if (search_over)
			rep.status = (opens_seen != 16'd0) ? ST_FOUND : ST_FAILED;
		rep.opens = opens_seen;
		rep.closes = closes_seen;
		rep.lines = lines_done;
		rep.close_line = close_line_q;
		rep.close_col = close_col_q;
		rep.open_col = first_open_col;
		rep.open_first = first_open_hit;
		return 1'b1;
	endfunction

	function void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
		end
	endfunction

	initial clear_search();

	always @(posedge clk) begin : line_checker
		line_report_t want;
		line_report_t made;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (line_reports.size() == 0) begin
				error_count++;
				$display("%0t unexpected line result: expected none actual %h", $time,
					m_axis_tdata);
			end else begin
				want = line_reports.pop_front();
				check_field("search_status", 16'(want.status), 16'(m_axis_tdata[1:0]));
				check_field("open_count", want.opens, m_axis_tdata[17:2]);
				check_field("close_count", want.closes, m_axis_tdata[33:18]);
				check_field("lines_seen", want.lines, m_axis_tdata[49:34]);
				check_field("close_line", want.close_line, m_axis_tdata[65:50]);
				check_field("close_column", 16'(want.close_col), 16'(m_axis_tdata[75:66]));
				check_field("open_column", 16'(want.open_col), 16'(m_axis_tdata[85:76]));
				check_field("open_in_first_line", 16'(want.open_first), 16'(m_axis_tdata[86]));
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			if (track_item(s_axis_tdata, s_axis_tlast, s_axis_tuser, made))
				line_reports.push_back(made);
		end
	end

	function int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return $urandom_range(1, 2);
		if (r < 93)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function int unsigned next_send_gap();
		if (fast_mode)
			return 0;
		if (send_calm > 0) begin
			send_calm--;
			return 0;
		end
		if ($urandom_range(0, 99) < 3) begin
			send_calm = $urandom_range(20, 80);
			return 0;
		end
		if ($urandom_range(0, 99) < 60)
			return 0;
		return idle_len();
	endfunction

	always @(posedge clk) begin
		if (fast_mode) begin
			m_axis_tready <= 1'b1;
		end else begin
			if (rx_left == 0) begin
				rx_on = !rx_on;
				if (rx_on)
					rx_left = ($urandom_range(0, 99) < 10) ? $urandom_range(30, 120)
						: $urandom_range(1, 8);
				else
					rx_left = idle_len();
			end
			rx_left--;
			m_axis_tready <= rx_on;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		do @(posedge clk); while (quiet_cycles < STALL_LIMIT);
		$display("delimiter_block_matcher regression: fail");
		$finish;
	end

	task automatic send_item(logic [7:0] c, bit le, bit rs);
		int unsigned gap;
		gap = next_send_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= le;
		s_axis_tuser <= rs;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic put_byte(logic [7:0] c);
		send_item(c, 1'b0, restart_pending);
		restart_pending = 1'b0;
	endtask

	task automatic put_line_end();
		send_item(8'($urandom_range(0, 255)), 1'b1, restart_pending);
		restart_pending = 1'b0;
	endtask

	task automatic put_pattern(logic [63:0] pat, int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			put_byte(pat[8*i +: 8]);
	endtask

	task automatic put_run(logic [7:0] c, int unsigned n);
		repeat (n) put_byte(c);
	endtask

	// let the line reports drain and the pipe settle before touching registers
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (line_reports.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_OPEN_PATTERN: open_pat = val;
			REG_OPEN_LENGTH: open_len = val[3:0];
			REG_CLOSE_PATTERN: close_pat = val;
			REG_CLOSE_LENGTH: close_len = val[3:0];
			default: ;
		endcase
	endtask

	task automatic load_delimiters(logic [63:0] op, logic [3:0] ol, logic [63:0] cp,
			logic [3:0] cl);
		quiesce();
		write_reg(REG_OPEN_PATTERN, op);
		write_reg(REG_OPEN_LENGTH, 64'(ol));
		write_reg(REG_CLOSE_PATTERN, cp);
		write_reg(REG_CLOSE_LENGTH, 64'(cl));
		cfg_valid <= 1'b0;
	endtask

	task automatic test_brace_defaults();
		restart_pending = 1'b1;
		put_line_end();
		put_line_end();
		restart_pending = 1'b1;
		put_byte("a");
		put_byte("{");
		put_byte("b");
		put_byte("}");
		put_line_end();
		restart_pending = 1'b1;
		put_byte("{");
		put_byte(8'h00);
		put_byte("{");
		put_byte(8'hFF);
		put_line_end();
		put_byte("}");
		put_line_end();
		put_byte("x");
		put_byte("}");
		put_line_end();
		// finished search ignores text and repeats its report
		put_byte("{");
		put_line_end();
	endtask

	task automatic test_delimiter_registers();
		// "/*" and "*/"
		load_delimiters(64'h2A2F, 4'd2, 64'h2F2A, 4'd2);
		restart_pending = 1'b1;
		put_pattern(64'h2F2A2A2F, 4);
		put_line_end();
		// overlapping text for a repeated-byte delimiter
		load_delimiters(64'h6161, 4'd2, 64'h62, 4'd1);
		restart_pending = 1'b1;
		put_pattern(64'h62616161, 4);
		put_line_end();
		// zero length acts as one byte, oversize length as eight
		load_delimiters(64'hA5A5_A5A5_A5A5_A500, 4'd0, '1, 4'd15);
		restart_pending = 1'b1;
		put_byte(8'h00);
		put_run(8'hFF, 8);
		put_line_end();
		// same delimiter for both sides
		load_delimiters(64'h5A5A_0000_0000_6261, 4'd2, 64'h0000_0000_0000_6261, 4'd2);
		restart_pending = 1'b1;
		put_pattern(64'h6261, 2);
		put_line_end();
	endtask

	task automatic test_long_line_columns();
		load_delimiters(64'h6261, 4'd2, 64'(RESET_CLOSE_CHAR), 4'd1);
		fast_mode = 1'b1;
		restart_pending = 1'b1;
		put_run("x", 1100);
		put_pattern(64'h6261, 2);
		put_byte(RESET_CLOSE_CHAR);
		put_line_end();
		fast_mode = 1'b0;
	endtask

	task automatic test_count_saturation();
		load_delimiters(64'(RESET_OPEN_CHAR), 4'd1, 64'(RESET_CLOSE_CHAR), 4'd1);
		fast_mode = 1'b1;
		restart_pending = 1'b1;
		put_run(RESET_OPEN_CHAR, 66000);
		put_line_end();
		put_run(RESET_CLOSE_CHAR, 66000);
		put_line_end();
		put_line_end();
		fast_mode = 1'b0;
	endtask

	task automatic test_line_count_saturation();
		fast_mode = 1'b1;
		restart_pending = 1'b1;
		put_byte(RESET_OPEN_CHAR);
		repeat (65540) put_line_end();
		put_byte(RESET_CLOSE_CHAR);
		put_line_end();
		fast_mode = 1'b0;
	endtask

	function automatic logic [63:0] make_pattern(int unsigned len);
		logic [63:0] p;
		p = {$urandom, $urandom};
		for (int unsigned i = 0; i < len; i++)
			p[8*i +: 8] = phase_syms[$urandom_range(0, 3)];
		return p;
	endfunction

	task automatic put_token();
		int unsigned k;
		int unsigned n;
		bit use_close;
		logic [63:0] p;
		k = $urandom_range(0, 99);
		use_close = (opens_seen > closes_seen) ? ($urandom_range(0, 3) != 0)
			: ($urandom_range(0, 1) == 1);
		p = use_close ? close_pat : open_pat;
		n = used_len(use_close ? close_len : open_len);
		if (k < 70) begin
			put_pattern(p, n);
		end else if (k < 85) begin
			if (n > 1)
				put_pattern(p, $urandom_range(1, n - 1));
			else
				put_byte(p[7:0] ^ 8'h01);
		end else if (k < 93) begin
			put_byte(phase_syms[$urandom_range(0, 3)]);
		end else begin
			put_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic run_search();
		int unsigned line_count;
		int unsigned tokens;
		if ($urandom_range(0, 9) == 0) begin
			restart_pending = 1'b0;
			repeat ($urandom_range(5, 30))
				send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
					$urandom_range(0, 15) == 0);
			return;
		end
		restart_pending = 1'b1;
		line_count = $urandom_range(1, 8);
		for (int unsigned l = 0; l < line_count; l++) begin
			tokens = $urandom_range(0, 6);
			repeat (tokens) put_token();
			put_line_end();
			if (search_over)
				break;
		end
		if (search_over && $urandom_range(0, 3) == 0) begin
			put_byte(8'($urandom_range(0, 255)));
			put_line_end();
		end
	endtask

	task automatic test_random_phases();
		int unsigned total_start;
		int unsigned phase_start;
		logic [3:0] ol;
		logic [3:0] cl;
		total_start = items_sent;
		for (int ph = 0; items_sent - total_start < RANDOM_ITEMS; ph++) begin
			case (ph)
				0: begin ol = 4'd1; cl = 4'd1; end
				1: begin ol = 4'd8; cl = 4'd8; end
				2: begin ol = 4'd0; cl = 4'd15; end
				3: begin ol = 4'd2; cl = 4'd3; end
				4: begin ol = 4'd15; cl = 4'd0; end
				5: begin ol = 4'd1; cl = 4'd8; end
				6: begin ol = 4'd8; cl = 4'd1; end
				default: begin
					ol = 4'($urandom_range(0, 15));
					cl = 4'($urandom_range(0, 15));
				end
			endcase
			for (int i = 0; i < 4; i++)
				phase_syms[i] = 8'($urandom_range(0, 255));
			if (ph == 0) begin
				phase_syms[0] = 8'h00;
				phase_syms[1] = 8'hFF;
			end
			load_delimiters(make_pattern(used_len(ol)), ol, make_pattern(used_len(cl)), cl);
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS
					&& items_sent - total_start < RANDOM_ITEMS)
				run_search();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_brace_defaults();
		test_delimiter_registers();
		test_long_line_columns();
		test_count_saturation();
		test_line_count_saturation();
		test_random_phases();
		quiesce();
		if (error_count == 0)
			$display("delimiter_block_matcher regression: pass");
		else
			$display("delimiter_block_matcher regression: fail");
		$finish;
	end

endmodule
